@@ design/mi3_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mi3_pkg;

   // Element format
   localparam int EW = 32;                 // element width
   localparam int FB = 16;                 // fraction bits
   // Low part of the quotient magnitude that saturation works on
   localparam int MAG_W = 64;

   localparam int PROD_W = 2 * EW;         // one element product
   localparam int COF_W  = 2 * EW + 1;     // signed cofactor
   localparam int CMAG_W = 2 * EW;         // cofactor magnitude
   localparam int TERM_W = 3 * EW + 1;     // element times cofactor
   localparam int DET_W  = 3 * EW + 3;     // signed determinant
   localparam int DMAG_W = 3 * EW + 2;     // determinant magnitude
   localparam int NUM_W  = CMAG_W + 2 * FB; // scaled numerator
   localparam int NHI_W  = NUM_W - MAG_W;  // quotient bits above the low part

   localparam int NLANE      = 9;
   localparam int PRE_DLY    = 4;          // cofactor wait for the determinant
   localparam int DIV_STAGES = NUM_W + 3;
   localparam int LATENCY    = 6 + DIV_STAGES;

   typedef logic signed [EW-1:0]    elem_type;
   typedef logic signed [COF_W-1:0] cof_type;
   typedef logic [DMAG_W-1:0]       dmag_type;

   typedef struct packed {
      logic     neg;
      logic     zero;
      dmag_type mag;
   } det_info_type;

endpackage

`default_nettype wire

@@ design/mi3_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface mi3_req_if;
   logic              valid;
   logic              ready;
   mi3_pkg::elem_type m00, m01, m02, m10, m11, m12, m20, m21, m22;

   modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   input ready);
   modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                 output ready);
endinterface

interface mi3_rsp_if;
   logic              valid;
   logic              ready;
   mi3_pkg::elem_type r00, r01, r02, r10, r11, r12, r20, r21, r22;
   logic              singular;

   modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                   singular, input ready);
   modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                 singular, output ready);
endinterface

`default_nettype wire

@@ design/matrix_inverse_3x3.sv @@
`timescale 1ns / 1ps
`default_nettype none

// 3x3 matrix inverse by the adjugate method, signed Q16.16 elements.
// The request channel (req) carries one matrix m00..m22 per request; the
// response channel (rsp) returns its inverse r00..r22 and a singular flag.
// Nine cofactor lanes work in parallel, a merging unit forms the
// determinant from row 0, and nine divider lanes each resolve one inverse
// element bit by bit, one quotient bit per pipeline stage.
// One request is accepted every cycle while the response side takes them,
// so throughput is one matrix per cycle. The 96 quotient-bit stages of the
// divider lanes make up most of the pipeline.
// A singular matrix (determinant exactly zero) returns all zeros with
// singular set. Out-of-range elements saturate.
// Synchronous reset empties the pipeline; data registers are not cleared.
// When the receiver stalls with a response waiting, the whole pipeline
// holds and req.ready falls with rsp.ready, so no request is lost.
module matrix_inverse_3x3 (
   input wire logic   clock,
   input wire logic   reset,
   mi3_req_if.sink    req,
   mi3_rsp_if.source  rsp
);

   localparam int NL  = mi3_pkg::NLANE;
   localparam int LAT = mi3_pkg::LATENCY;
   localparam int DS  = mi3_pkg::DIV_STAGES;

   logic              en;
   logic              valid_in [LAT], valid_ff [LAT];
   mi3_pkg::elem_type m [3][3];
   mi3_pkg::elem_type m0_d1_ff [3], m0_d2_ff [3];
   mi3_pkg::cof_type  cof [NL];
   mi3_pkg::cof_type  cof_dly_ff [mi3_pkg::PRE_DLY][NL];
   mi3_pkg::det_info_type det;
   logic              sing_ff [DS];
   mi3_pkg::elem_type res [NL];
   mi3_pkg::cof_type  cof_row0 [3];

   // Every stage advances together unless a finished response is waiting.
   assign en        = !valid_ff[LAT-1] || rsp.ready;
   assign req.ready = en;

   assign m[0][0] = req.m00;  assign m[0][1] = req.m01;  assign m[0][2] = req.m02;
   assign m[1][0] = req.m10;  assign m[1][1] = req.m11;  assign m[1][2] = req.m12;
   assign m[2][0] = req.m20;  assign m[2][1] = req.m21;  assign m[2][2] = req.m22;

   // Cofactor lanes: lane k*3+l holds the cofactor of element (k,l).
   for (genvar k = 0; k < 3; k++) begin : g_row
      for (genvar l = 0; l < 3; l++) begin : g_col
         mi3_cof_lane u_cof (
            .clock (clock),
            .en    (en),
            .a_i   (m[(k+1)%3][(l+1)%3]),
            .b_i   (m[(k+2)%3][(l+2)%3]),
            .c_i   (m[(k+1)%3][(l+2)%3]),
            .d_i   (m[(k+2)%3][(l+1)%3]),
            .cof_o (cof[k*3+l])
         );
      end
   end

   assign cof_row0[0] = cof[0];
   assign cof_row0[1] = cof[1];
   assign cof_row0[2] = cof[2];

   // Determinant merge; row 0 elements pass two delay registers to meet their cofactors.
   mi3_det u_det (
      .clock (clock),
      .en    (en),
      .m_i   (m0_d2_ff),
      .cof_i (cof_row0),
      .det_o (det)
   );

   // Divider lanes: inverse element (i,j) comes from the cofactor of (j,i).
   for (genvar i = 0; i < 3; i++) begin : g_out_row
      for (genvar j = 0; j < 3; j++) begin : g_out_col
         mi3_div_lane u_div (
            .clock (clock),
            .en    (en),
            .cof_i (cof_dly_ff[mi3_pkg::PRE_DLY-1][j*3+i]),
            .det_i (det),
            .r_o   (res[i*3+j])
         );
      end
   end

   always_comb begin
      valid_in[0] = req.valid;
      for (int s = 1; s < LAT; s++) begin
         valid_in[s] = valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < LAT; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < 3; l++) begin
            m0_d1_ff[l] <= m[0][l];
            m0_d2_ff[l] <= m0_d1_ff[l];
         end
         cof_dly_ff[0] <= cof;
         for (int s = 1; s < mi3_pkg::PRE_DLY; s++) begin
            cof_dly_ff[s] <= cof_dly_ff[s-1];
         end
         sing_ff[0] <= det.zero;
         for (int s = 1; s < DS; s++) begin
            sing_ff[s] <= sing_ff[s-1];
         end
      end
   end

   // A singular matrix forces every element of the response to zero.
   assign rsp.valid    = valid_ff[LAT-1];
   assign rsp.singular = sing_ff[DS-1];
   assign rsp.r00 = sing_ff[DS-1] ? '0 : res[0];
   assign rsp.r01 = sing_ff[DS-1] ? '0 : res[1];
   assign rsp.r02 = sing_ff[DS-1] ? '0 : res[2];
   assign rsp.r10 = sing_ff[DS-1] ? '0 : res[3];
   assign rsp.r11 = sing_ff[DS-1] ? '0 : res[4];
   assign rsp.r12 = sing_ff[DS-1] ? '0 : res[5];
   assign rsp.r20 = sing_ff[DS-1] ? '0 : res[6];
   assign rsp.r21 = sing_ff[DS-1] ? '0 : res[7];
   assign rsp.r22 = sing_ff[DS-1] ? '0 : res[8];

endmodule

`default_nettype wire

@@ design/mi3_cof_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One cofactor: a*b - c*d, two stages.
module mi3_cof_lane (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire mi3_pkg::elem_type a_i,
   input  wire mi3_pkg::elem_type b_i,
   input  wire mi3_pkg::elem_type c_i,
   input  wire mi3_pkg::elem_type d_i,
   output mi3_pkg::cof_type       cof_o
);

   logic signed [mi3_pkg::PROD_W-1:0] p1_in, p2_in, p1_ff, p2_ff;
   mi3_pkg::cof_type                  cof_in, cof_ff;

   assign p1_in  = a_i * b_i;
   assign p2_in  = c_i * d_i;
   assign cof_in = mi3_pkg::COF_W'(p1_ff) - mi3_pkg::COF_W'(p2_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff  <= p1_in;
         p2_ff  <= p2_in;
         cof_ff <= cof_in;
      end
   end

   assign cof_o = cof_ff;

endmodule

`default_nettype wire

@@ design/mi3_det.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Determinant by expansion along row 0, four stages. The 65-bit cofactor is
// split so that no multiplier exceeds 32 by 33 bits.
module mi3_det (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire mi3_pkg::elem_type m_i   [3],
   input  wire mi3_pkg::cof_type  cof_i [3],
   output mi3_pkg::det_info_type  det_o
);

   localparam int EW = mi3_pkg::EW;

   logic signed [2*EW:0]                phi_in [3], plo_in [3], phi_ff [3], plo_ff [3];
   logic signed [mi3_pkg::TERM_W-1:0]   term_in [3], term_ff [3];
   logic signed [mi3_pkg::DET_W-1:0]    det_in, det_ff, det_neg;
   mi3_pkg::det_info_type               info_in, info_ff;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         phi_in[l]  = m_i[l] * $signed(cof_i[l][mi3_pkg::COF_W-1:EW]);
         plo_in[l]  = m_i[l] * $signed({1'b0, cof_i[l][EW-1:0]});
         term_in[l] = (mi3_pkg::TERM_W'(phi_ff[l]) <<< EW) + mi3_pkg::TERM_W'(plo_ff[l]);
      end
   end

   assign det_in = mi3_pkg::DET_W'(term_ff[0]) + mi3_pkg::DET_W'(term_ff[1])
                 + mi3_pkg::DET_W'(term_ff[2]);
   assign det_neg = -det_ff;

   always_comb begin
      info_in.neg  = det_ff[mi3_pkg::DET_W-1];
      info_in.zero = (det_ff == '0);
      info_in.mag  = info_in.neg ? mi3_pkg::DMAG_W'(det_neg) : mi3_pkg::DMAG_W'(det_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         phi_ff  <= phi_in;
         plo_ff  <= plo_in;
         term_ff <= term_in;
         det_ff  <= det_in;
         info_ff <= info_in;
      end
   end

   assign det_o = info_ff;

endmodule

`default_nettype wire

@@ design/mi3_div_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Scaled cofactor over determinant: restoring division, one quotient bit
// per stage, then saturation to the element range.
module mi3_div_lane (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire mi3_pkg::cof_type      cof_i,
   input  wire mi3_pkg::det_info_type det_i,
   output mi3_pkg::elem_type          r_o
);

   localparam int EW    = mi3_pkg::EW;
   localparam int MAG_W = mi3_pkg::MAG_W;
   localparam int NUM_W = mi3_pkg::NUM_W;
   localparam int DW    = mi3_pkg::DMAG_W;

   // magnitude stage
   logic [mi3_pkg::CMAG_W-1:0] mag_in, mag_ff;
   logic                       neg_in, gneg_ff;
   mi3_pkg::dmag_type          gden_ff;
   mi3_pkg::cof_type           cof_neg;

   // division stages; index 0 holds the set-up values
   logic [NUM_W-1:0]          num;
   logic [DW-1:0]             rem_in [NUM_W+1], rem_ff [NUM_W+1];
   logic [NUM_W-1:0]          low_in [NUM_W+1], low_ff [NUM_W+1];
   logic [NUM_W-1:0]          q_in   [NUM_W+1], q_ff   [NUM_W+1];
   logic                      neg_ff [NUM_W+1];
   mi3_pkg::dmag_type         den_ff [NUM_W+1];

   logic [MAG_W-1:0]  qmag, limit, sat;
   logic              over, rneg;
   mi3_pkg::elem_type r_in, r_ff;

   assign cof_neg = -cof_i;
   assign neg_in  = cof_i[mi3_pkg::COF_W-1] ^ det_i.neg;
   assign mag_in  = cof_i[mi3_pkg::COF_W-1] ? mi3_pkg::CMAG_W'(cof_neg)
                                            : mi3_pkg::CMAG_W'(cof_i);

   assign num       = NUM_W'(mag_ff) << (2 * mi3_pkg::FB);
   assign rem_in[0] = '0;
   assign low_in[0] = num;
   assign q_in[0]   = '0;

   for (genvar s = 1; s <= NUM_W; s++) begin : g_step
      logic [DW:0] trial, diff;
      logic        ge;
      always_comb begin
         trial     = {rem_ff[s-1], low_ff[s-1][NUM_W-1]};
         diff      = trial - {1'b0, den_ff[s-1]};
         ge        = (trial >= {1'b0, den_ff[s-1]});
         rem_in[s] = ge ? diff[DW-1:0] : trial[DW-1:0];
         low_in[s] = low_ff[s-1] << 1;
         q_in[s]   = {q_ff[s-1][NUM_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff    <= mag_in;
         gneg_ff   <= neg_in;
         gden_ff   <= det_i.mag;
         rem_ff[0] <= rem_in[0];
         low_ff[0] <= low_in[0];
         q_ff[0]   <= q_in[0];
         neg_ff[0] <= gneg_ff;
         den_ff[0] <= gden_ff;
         for (int s = 1; s <= NUM_W; s++) begin
            rem_ff[s] <= rem_in[s];
            low_ff[s] <= low_in[s];
            q_ff[s]   <= q_in[s];
            neg_ff[s] <= neg_ff[s-1];
            den_ff[s] <= den_ff[s-1];
         end
         r_ff <= r_in;
      end
   end

   // A low part of zero drops the sign, even when the quotient overflowed
   // above it.
   always_comb begin
      qmag  = q_ff[NUM_W][MAG_W-1:0];
      over  = |q_ff[NUM_W][NUM_W-1 -: mi3_pkg::NHI_W];
      rneg  = neg_ff[NUM_W] && (qmag != '0);
      limit = rneg ? (MAG_W'(1) << (EW - 1)) : ((MAG_W'(1) << (EW - 1)) - MAG_W'(1));
      sat   = (over || (qmag > limit)) ? limit : qmag;
      r_in  = rneg ? -EW'(sat) : EW'(sat);
   end

   assign r_o = r_ff;

endmodule

`default_nettype wire
